@@ src/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the priority table rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

@@ src/gmpt_pkg.sv @@
// ---------------------------------------------------------------------------
// gmpt_pkg
// types and constants shared by the grouped max priority table
// ---------------------------------------------------------------------------
`default_nettype none

package gmpt_pkg;

   localparam int KEY_W      = 64;
   localparam int PRIO_W     = 31;
   localparam int REQ_DATA_W = 168;
   localparam int RSP_DATA_W = 72;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_UPDATE = 2'd1,
      OP_QUERY  = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_NOT_FOUND = 2'd1,
      STAT_FULL      = 2'd2,
      STAT_DUPLICATE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_COMMIT
   } state_type;

   // probe that walks the cell row, collecting results as it goes
   typedef struct packed {
      logic              valid;
      op_type            op;
      logic [KEY_W-1:0]  key;
      logic [KEY_W-1:0]  group;
      logic [PRIO_W-1:0] prio;
      logic              hit;
      logic              free_found;
      logic              best_found;
      logic [PRIO_W-1:0] best_prio;
      logic [KEY_W-1:0]  best_name;
   } probe_type;

   // broadcast write into one cell
   typedef struct packed {
      logic              valid;
      logic              insert;
      logic [KEY_W-1:0]  name;
      logic [KEY_W-1:0]  group;
      logic [PRIO_W-1:0] prio;
   } write_type;

endpackage

`default_nettype wire

@@ src/gmpt_cell.sv @@
// ---------------------------------------------------------------------------
// gmpt_cell
// one table slot plus one stage of the probe chain
// ---------------------------------------------------------------------------
`default_nettype none

module gmpt_cell
   import gmpt_pkg::*;
#(
   parameter int IDX_W      = 6,
   parameter int CELL_INDEX = 0
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire probe_type        pkt_i,
   input  wire logic [IDX_W-1:0] hit_idx_i,
   input  wire logic [IDX_W-1:0] free_idx_i,
   input  wire write_type        wr_i,
   input  wire logic [IDX_W-1:0] wr_idx_i,
   output probe_type             pkt_o,
   output logic      [IDX_W-1:0] hit_idx_o,
   output logic      [IDX_W-1:0] free_idx_o
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

   logic              valid_ff;
   logic [KEY_W-1:0]  name_ff;
   logic [KEY_W-1:0]  group_ff;
   logic [PRIO_W-1:0] prio_ff;

   probe_type         pkt_ff, pkt_in;
   logic [IDX_W-1:0]  hit_idx_ff, hit_idx_in;
   logic [IDX_W-1:0]  free_idx_ff, free_idx_in;

   logic name_match, group_match, better, wr_sel;

   assign name_match  = valid_ff && (name_ff == pkt_i.key);
   assign group_match = valid_ff && (group_ff == pkt_i.group);
   assign better      = !pkt_i.best_found || (prio_ff > pkt_i.best_prio) ||
                        ((prio_ff == pkt_i.best_prio) && (name_ff < pkt_i.best_name));
   assign wr_sel      = wr_i.valid && (wr_idx_i == MY_IDX);

   always_comb begin
      pkt_in      = pkt_i;
      hit_idx_in  = hit_idx_i;
      free_idx_in = free_idx_i;
      if (name_match && !pkt_i.hit) begin
         pkt_in.hit = 1'b1;
         hit_idx_in = MY_IDX;
      end
      // lowest free slot wins
      if (!valid_ff && !pkt_i.free_found) begin
         pkt_in.free_found = 1'b1;
         free_idx_in       = MY_IDX;
      end
      if (group_match && better) begin
         pkt_in.best_found = 1'b1;
         pkt_in.best_prio  = prio_ff;
         pkt_in.best_name  = name_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pkt_ff <= '0;
      end else begin
         pkt_ff <= pkt_in;
      end
      hit_idx_ff  <= hit_idx_in;
      free_idx_ff <= free_idx_in;
   end

   // slot storage, only the valid bit is reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (wr_sel && wr_i.insert) begin
         valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_sel) begin
         prio_ff <= wr_i.prio;
         if (wr_i.insert) begin
            name_ff  <= wr_i.name;
            group_ff <= wr_i.group;
         end
      end
   end

   assign pkt_o      = pkt_ff;
   assign hit_idx_o  = hit_idx_ff;
   assign free_idx_o = free_idx_ff;

endmodule

`default_nettype wire

@@ src/gmpt_ctrl.sv @@
// ---------------------------------------------------------------------------
// gmpt_ctrl
// launches probes, collects them from the chain end and commits results
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module gmpt_ctrl
   import gmpt_pkg::*;
#(
   parameter int IDX_W = 6
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic      [RSP_DATA_W-1:0] rsp_tdata,
   output probe_type                  head_o,
   input  wire probe_type             tail_i,
   input  wire logic [IDX_W-1:0]      tail_hit_idx_i,
   input  wire logic [IDX_W-1:0]      tail_free_idx_i,
   output write_type                  wr_o,
   output logic      [IDX_W-1:0]      wr_idx_o
);

   state_type               state_ff, state_in;
   probe_type               head_ff, head_in;
   probe_type               done_ff, done_in;
   logic [IDX_W-1:0]        hit_idx_ff, hit_idx_in;
   logic [IDX_W-1:0]        free_idx_ff, free_idx_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;

   logic                    accept, fire, do_write;
   status_type              status;
   logic [KEY_W-1:0]        best;

   assign accept = req_tvalid && req_tready;
   assign fire   = (state_ff == S_COMMIT) && (!rsp_valid_ff || rsp_tready);

   // result of the finished probe
   always_comb begin
      status   = STAT_OK;
      best     = '0;
      do_write = 1'b0;
      wr_idx_o = hit_idx_ff;
      unique case (done_ff.op)
         OP_INSERT: begin
            wr_idx_o = free_idx_ff;
            if (done_ff.hit) begin
               status = STAT_DUPLICATE;
            end else if (!done_ff.free_found) begin
               status = STAT_FULL;
            end else begin
               do_write = 1'b1;
            end
         end
         OP_UPDATE: begin
            if (!done_ff.hit) begin
               status = STAT_NOT_FOUND;
            end else begin
               do_write = 1'b1;
            end
         end
         OP_QUERY: begin
            if (done_ff.best_found) begin
               best = done_ff.best_name;
            end else begin
               status = STAT_NOT_FOUND;
            end
         end
         default: begin
         end
      endcase
      wr_o.valid  = fire && do_write;
      wr_o.insert = (done_ff.op == OP_INSERT);
      wr_o.name   = done_ff.key;
      wr_o.group  = done_ff.group;
      wr_o.prio   = done_ff.prio;
   end

   always_comb begin
      state_in     = state_ff;
      req_tready   = (state_ff == S_IDLE);
      head_in      = head_ff;
      head_in.valid = 1'b0;
      done_in      = done_ff;
      hit_idx_in   = hit_idx_ff;
      free_idx_in  = free_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               head_in            = '0;
               head_in.valid      = 1'b1;
               head_in.op         = op_type'(req_tdata[1:0]);
               head_in.key        = req_tdata[65:2];
               head_in.group      = req_tdata[129:66];
               head_in.prio       = req_tdata[160:130];
               state_in           = S_SCAN;
            end
         end
         S_SCAN: begin
            if (tail_i.valid) begin
               done_in     = tail_i;
               hit_idx_in  = tail_hit_idx_i;
               free_idx_in = tail_free_idx_i;
               state_in    = S_COMMIT;
            end
         end
         S_COMMIT: begin
            if (fire) begin
               rsp_valid_in       = 1'b1;
               rsp_data_in        = '0;
               rsp_data_in[63:0]  = best;
               rsp_data_in[65:64] = status;
               state_in           = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
      end else begin
         head_ff <= head_in;
      end
      done_ff     <= done_in;
      hit_idx_ff  <= hit_idx_in;
      free_idx_ff <= free_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign head_o     = head_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `ASSERT_IMPLIES(a_tail_only_in_scan, clock, reset, tail_i.valid, state_ff == S_SCAN)
   `ASSERT_NEXT(a_accept_starts_scan, clock, reset, accept, state_ff == S_SCAN && head_ff.valid)
   `ASSERT_IMPLIES(a_write_with_result, clock, reset, wr_o.valid, fire && status == STAT_OK)

endmodule

`default_nettype wire

@@ src/grouped_max_priority_table.sv @@
// ---------------------------------------------------------------------------
// grouped_max_priority_table
// keyed table of (name, group, priority) entries with insert, update by
// name and best-in-group query, built as a row of slot cells
// ---------------------------------------------------------------------------
//
//   channel   direction  tdata fields (lsb first)                  tuser
//   req_*     in         operation, item_key, group_key,            -
//                        priority_req, zero pad to 168 bits
//   rsp_*     out        best_key, status, zero pad to 72 bits      -
//
// from accept to the next accept an item passes through the launch register,
// then the register of each cell as the probe walks the slot row, then the
// capture at the row end and last the commit of the write, which also loads
// the response register
// the response register frees the input side, a new beat is taken while
// the previous result still waits on rsp_tready
// a stalled response holds the commit of the following item
// reset is synchronous, clears all slot valid bits at once, no sweep
// ---------------------------------------------------------------------------
`default_nettype none

module grouped_max_priority_table
   import gmpt_pkg::*;
#(
   parameter int TABLE_ENTRIES = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // operation[1:0], item_key[65:2], group_key[129:66], priority_req[160:130]
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // best_key[63:0], status[65:64]
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic      [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   // probe chain: stage 0 is the launch register, stage TABLE_ENTRIES the row end
   probe_type        pkt      [TABLE_ENTRIES+1];
   logic [IDX_W-1:0] hit_idx  [TABLE_ENTRIES+1];
   logic [IDX_W-1:0] free_idx [TABLE_ENTRIES+1];

   // commit write, broadcast to every cell
   write_type        wr;
   logic [IDX_W-1:0] wr_idx;

   assign hit_idx[0]  = '0;
   assign free_idx[0] = '0;

   gmpt_ctrl #(
      .IDX_W (IDX_W)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .head_o          (pkt[0]),
      .tail_i          (pkt[TABLE_ENTRIES]),
      .tail_hit_idx_i  (hit_idx[TABLE_ENTRIES]),
      .tail_free_idx_i (free_idx[TABLE_ENTRIES]),
      .wr_o            (wr),
      .wr_idx_o        (wr_idx)
   );

   // one cell per slot, each passes the probe on to its neighbor
   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      gmpt_cell #(
         .IDX_W      (IDX_W),
         .CELL_INDEX (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .pkt_i      (pkt[i]),
         .hit_idx_i  (hit_idx[i]),
         .free_idx_i (free_idx[i]),
         .wr_i       (wr),
         .wr_idx_i   (wr_idx),
         .pkt_o      (pkt[i+1]),
         .hit_idx_o  (hit_idx[i+1]),
         .free_idx_o (free_idx[i+1])
      );
   end

endmodule

`default_nettype wire
